### rtl/sliding_window_average_defines.svh
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_DEFINES_SVH

// same-cycle implication
`define SWA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swa_pkg.sv
`timescale 1ns / 1ps

package swa_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
    logic cfg_write;
  } swa_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } swa_status_t;

endpackage

### rtl/swa_ram.sv
`timescale 1ns / 1ps

module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/swa_ctrl.sv
`timescale 1ns / 1ps

module swa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  swa_pkg::swa_status_t status,
  output swa_pkg::swa_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/swa_dp.sv
`timescale 1ns / 1ps

module swa_dp #(
  parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swa_pkg::swa_cmd_t                 cmd,
  output swa_pkg::swa_status_t              status,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   cfg_window_length,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_average,
  output logic [$clog2(MAX_WINDOW+1)-1:0]   out_samples_held,
  output logic                              out_window_full
);

  localparam int HELD_W = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int EXT_W  = SUM_W - SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [HELD_W-1:0]      held_r, held_nxt;
  logic [HELD_W-1:0]      wlen_r, wlen_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [HELD_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [HELD_W-1:0]      oheld_r, oheld_nxt;
  logic                   ofull_r, ofull_nxt;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   full;
  logic [SUM_W-1:0]       old_ext;
  logic [SUM_W-1:0]       new_ext;
  logic [SUM_W-1:0]       sum_upd;
  logic [SUM_W-1:0]       quo_signed;
  logic [HELD_W-1:0]      slot_inc;
  logic [HELD_W:0]        trial;
  logic [HELD_W:0]        diff;
  logic                   ge;

  swa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (cmd.accept),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // ring update terms
  assign full     = (held_r == wlen_r);
  assign old_ext  = {{EXT_W{rd_data[SAMPLE_BITS-1]}}, rd_data};
  assign new_ext  = {{EXT_W{sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign sum_upd  = sum_r + new_ext - (full ? old_ext : '0);
  assign slot_inc = HELD_W'(slot_r) + HELD_W'(1);

  // restoring divide step on magnitudes
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, held_r};
  assign ge    = (trial >= {1'b0, held_r});

  assign quo_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

  always_comb begin
    sample_nxt    = sample_r;
    slot_nxt      = slot_r;
    held_nxt      = held_r;
    wlen_nxt      = wlen_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    avg_nxt       = avg_r;
    oheld_nxt     = oheld_r;
    ofull_nxt     = ofull_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.cfg_write) begin
      if (cfg_window_length == '0) begin
        wlen_nxt = HELD_W'(1);
      end else if (cfg_window_length > HELD_W'(MAX_WINDOW)) begin
        wlen_nxt = HELD_W'(MAX_WINDOW);
      end else begin
        wlen_nxt = cfg_window_length;
      end
      slot_nxt = '0;
      held_nxt = '0;
      sum_nxt  = '0;
    end

    if (cmd.accept) begin
      sample_nxt = in_sample;
    end

    if (cmd.update) begin
      if (!full) begin
        held_nxt = held_r + HELD_W'(1);
      end
      sum_nxt  = sum_upd;
      slot_nxt = (slot_inc >= wlen_r) ? '0 : slot_inc[SLOT_W-1:0];
      neg_nxt  = sum_upd[SUM_W-1];
      quo_nxt  = sum_upd[SUM_W-1] ? (~sum_upd + SUM_W'(1)) : sum_upd;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end

    if (cmd.div_step) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[HELD_W-1:0] : trial[HELD_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.load_out) begin
      avg_nxt       = quo_signed[SAMPLE_BITS-1:0];
      oheld_nxt     = held_r;
      ofull_nxt     = full;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      held_r      <= '0;
      wlen_r      <= HELD_W'(MAX_WINDOW);
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      wlen_r      <= wlen_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    avg_r    <= avg_nxt;
    oheld_r  <= oheld_nxt;
    ofull_r  <= ofull_nxt;
  end

  assign status.div_last = (cnt_r == CNT_W'(SUM_W - 1));
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_average      = avg_r;
  assign out_samples_held = oheld_r;
  assign out_window_full  = ofull_r;

endmodule

### rtl/sliding_window_average.sv
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid / in_stall | in_sample
// out     | out_valid/out_stall | out_average, out_samples_held, out_window_full
// cfg     | cfg_valid/cfg_ready | cfg_window_length
//
// one word at a time: accept, ring read, sum update, then a restoring divider
// that retires one quotient bit per cycle (SAMPLE_BITS + clog2(MAX_WINDOW) steps)
// a result waiting under out_stall holds the block before it returns to idle
// synchronous active-low reset restores window length MAX_WINDOW and empties the window

module sliding_window_average #(
  parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   out_average,
  output logic [$clog2(MAX_WINDOW+1)-1:0] out_samples_held,
  output logic                            out_window_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] cfg_window_length
);

  swa_pkg::swa_cmd_t    cmd;
  swa_pkg::swa_status_t status;

  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  swa_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_sample         (in_sample),
    .cfg_window_length (cfg_window_length),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_average       (out_average),
    .out_samples_held  (out_samples_held),
    .out_window_full   (out_window_full)
  );

endmodule

### rtl/swa_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_average_defines.svh"

module swa_checker #(
  parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [SAMPLE_BITS-1:0]          out_average,
  input logic [$clog2(MAX_WINDOW+1)-1:0] out_samples_held,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  localparam int HELD_W = $clog2(MAX_WINDOW + 1);

  // stalled result word holds
  `SWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_average), "stalled result changed")

  // count stays between one and MAX_WINDOW
  `SWA_ASSERT_SAME(a_held_range, clk, rst_n, out_valid, (out_samples_held != '0) && (out_samples_held <= HELD_W'(MAX_WINDOW)), "samples_held out of range")

  // busy right after taking a word
  `SWA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

  // config write and word accept never coincide
  `SWA_ASSERT_SAME(a_cfg_excl, clk, rst_n, in_valid && !in_stall, !(cfg_valid && cfg_ready), "config write during accept")

endmodule

bind sliding_window_average swa_checker #(
  .MAX_WINDOW  (MAX_WINDOW),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_average      (out_average),
  .out_samples_held (out_samples_held),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);

### sim/sliding_window_average_test.sv
`timescale 1ns / 1ps

typedef logic signed [swa_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
typedef logic [$clog2(swa_pkg::MAX_WINDOW_DEF+1)-1:0] count_t;

typedef struct {
  sample_t average;
  count_t  held;
  logic    full;
} avg_result_t;

class avg_scoreboard;
  sample_t     ring [swa_pkg::MAX_WINDOW_DEF];
  int unsigned win_len;
  int unsigned slot;
  int unsigned held;
  longint      total;
  avg_result_t due [$];
  int          errors;

  function new();
    win_len = swa_pkg::MAX_WINDOW_DEF;
    errors = 0;
    restart();
  endfunction

  function void restart();
    slot = 0;
    held = 0;
    total = 0;
  endfunction

  function void set_length(count_t v);
    int unsigned w;
    w = v;
    if (w < 1) w = 1;
    if (w > swa_pkg::MAX_WINDOW_DEF) w = swa_pkg::MAX_WINDOW_DEF;
    win_len = w;
    restart();
  endfunction

  function void note_sample(sample_t s);
    avg_result_t r;
    longint q;
    if (held < win_len) held++;
    else total -= ring[slot];
    ring[slot] = s;
    total += s;
    slot++;
    if (slot >= win_len) slot = 0;
    q = total / longint'(held);
    r.average = sample_t'(q);
    r.held = count_t'(held);
    r.full = (held == win_len);
    due.push_back(r);
  endfunction

  function int pending();
    return due.size();
  endfunction

  task report(string what);
    $display("%0t: %s", $time, what);
    errors++;
  endtask

  task check_result(sample_t avg, count_t n, logic full);
    avg_result_t e;
    if (due.size() == 0) begin
      report($sformatf("unexpected word avg %0d held %0d full %0b", avg, n, full));
      return;
    end
    e = due.pop_front();
    if (avg !== e.average || n !== e.held || full !== e.full) begin
      report($sformatf("got avg %0d held %0d full %0b, want avg %0d held %0d full %0b",
                       avg, n, full, e.average, e.held, e.full));
    end
  endtask
endclass

module sliding_window_average_test;

  localparam int RANDOM_ITEMS   = 500;
  localparam int LAST_LEG       = 60;
  localparam int SETTLE_CYCLES  = 32;
  localparam int PROGRESS_LIMIT = 2000;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  sample_t in_sample;
  logic    out_valid;
  logic    out_stall;
  sample_t out_average;
  count_t  out_samples_held;
  logic    out_window_full;
  logic    cfg_valid;
  logic    cfg_ready;
  count_t  cfg_window_length;

  avg_scoreboard sb = new();
  int idle_odds = 0;
  int stall_odds = 0;
  int idle_run = 0;

  sliding_window_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average      (out_average),
    .out_samples_held (out_samples_held),
    .out_window_full  (out_window_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_sample(input sample_t v);
    int gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input count_t v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_window_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // scoreboard hookup and progress watchdog
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_sample);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_length(cfg_window_length);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_average, out_samples_held, out_window_full);
        moved = 1'b1;
      end
    end
    if (!rst_n || moved) idle_run = 0;
    else idle_run++;
    if (idle_run >= PROGRESS_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding",
               PROGRESS_LIMIT, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : result_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    bit last_leg;
    count_t w;
    sample_t s;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_window_length <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default window, extremes, saturating lengths, rounding toward zero
    idle_odds = 3;
    stall_odds = 3;
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    set_window(7'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    set_window(7'd2);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd2);
    send_sample(-16'sd3);
    set_window(7'd127);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    set_window(7'd65);
    send_sample(-16'sd3);
    send_sample(16'sd2);
    set_window(7'd64);
    send_sample(-16'sd7);
    send_sample(16'sd4);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      last_leg = (sent >= RANDOM_ITEMS - LAST_LEG);
      idle_odds = last_leg ? 0 : $urandom_range(0, 3) * 3;
      stall_odds = last_leg ? 0 : $urandom_range(0, 3) * 3;
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0: w = 7'd0;
          1: w = count_t'($urandom_range(65, 127));
          2: w = 7'd64;
          3: w = 7'd1;
          4: w = 7'd127;
          default: w = count_t'($urandom_range(2, 12));
        endcase
        set_window(w);
      end
      if (last_leg) begin
        n = RANDOM_ITEMS - sent;
      end else begin
        n = $urandom_range(10, 80);
        if (sent + n > RANDOM_ITEMS - LAST_LEG) n = RANDOM_ITEMS - LAST_LEG - sent;
      end
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: s = 16'sh7fff;
          1: s = 16'sh8000;
          2: s = sample_t'($urandom_range(0, 16)) - 16'sd8;
          default: s = sample_t'($urandom());
        endcase
        send_sample(s);
      end
      sent += n;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
